FILE: rtl/d8fd_pkg.sv
// ============================================================================
// d8fd_pkg : shared types and constants for the D8 flow direction block
// Request and result structs, direction codes, border codes and the
// neighbour order tables used by the slope and resolve stages.
// ============================================================================
package d8fd_pkg;

  localparam int NBR_COUNT = 8;
  localparam int DIR_W     = 8;
  localparam int FLOW_W    = 9;
  localparam int FIELD_W   = 32;

  // Slope weights: cardinal drops scale by sqrt2 (Q15), diagonal drops by one.
  localparam logic [15:0] Q15_SQRT2 = 16'd46341;
  localparam logic [15:0] Q15_ONE   = 16'd32768;

  // Border kinds; other codes count as interior.
  localparam logic [2:0] BORDER_FIRST_ROW = 3'd1;
  localparam logic [2:0] BORDER_LAST_ROW  = 3'd2;
  localparam logic [2:0] BORDER_FIRST_COL = 3'd3;
  localparam logic [2:0] BORDER_LAST_COL  = 3'd4;

  // Direction bits.
  localparam logic [DIR_W-1:0] DIR_NE = 8'd1;
  localparam logic [DIR_W-1:0] DIR_E  = 8'd2;
  localparam logic [DIR_W-1:0] DIR_SE = 8'd4;
  localparam logic [DIR_W-1:0] DIR_S  = 8'd8;
  localparam logic [DIR_W-1:0] DIR_SW = 8'd16;
  localparam logic [DIR_W-1:0] DIR_W_ = 8'd32;
  localparam logic [DIR_W-1:0] DIR_NW = 8'd64;
  localparam logic [DIR_W-1:0] DIR_N  = 8'd128;

  localparam logic signed [FLOW_W-1:0] FLOW_PIT = -9'sd256;

  typedef struct packed {
    logic signed [FIELD_W-1:0] center_elev;
    logic signed [FIELD_W-1:0] nw_elev;
    logic signed [FIELD_W-1:0] north_elev;
    logic signed [FIELD_W-1:0] ne_elev;
    logic signed [FIELD_W-1:0] west_elev;
    logic signed [FIELD_W-1:0] east_elev;
    logic signed [FIELD_W-1:0] sw_elev;
    logic signed [FIELD_W-1:0] south_elev;
    logic signed [FIELD_W-1:0] se_elev;
    logic        [2:0]         border_kind;
  } d8fd_in_t;

  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_dir;
    logic                     dir_is_null;
  } d8fd_out_t;

  // Decisions taken ahead of the slope compare.
  typedef struct packed {
    logic             is_null;
    logic             forced;
    logic [DIR_W-1:0] forced_dir;
  } d8fd_ctrl_t;

  // Neighbour order: NW, N, NE, W, E, SW, S, SE.
  function automatic logic [DIR_W-1:0] dir_bit(input logic [2:0] idx);
    logic [DIR_W-1:0] b;
    case (idx)
      3'd0:    b = DIR_NW;
      3'd1:    b = DIR_N;
      3'd2:    b = DIR_NE;
      3'd3:    b = DIR_W_;
      3'd4:    b = DIR_E;
      3'd5:    b = DIR_SW;
      3'd6:    b = DIR_S;
      default: b = DIR_SE;
    endcase
    return b;
  endfunction

  function automatic logic dir_diag(input logic [2:0] idx);
    logic d;
    case (idx)
      3'd0, 3'd2, 3'd5, 3'd7: d = 1'b1;
      default:                d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/d8_flow_direction_top.sv
// ============================================================================
// d8_flow_direction_top : D8 flow direction of one 3x3 elevation window
// Five-register pipeline: request, slope keys, two maximum-tree stages and
// the registered result.
// ============================================================================
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The maximum tree over eight keys sets the stage count.
// Reset: synchronous, active low; clears the valid bits, drops requests in
// flight, and leaves payload registers as they are.
module d8_flow_direction_top #(
  parameter int ELEV_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  d8fd_pkg::d8fd_in_t  in_item,
  output logic                out_strobe,
  output d8fd_pkg::d8fd_out_t out_result
);
  import d8fd_pkg::*;

  // Weighted drop needs the drop width plus the 16-bit weight, plus a sign.
  localparam int KEY_W = ELEV_WIDTH + 18;
  localparam logic [ELEV_WIDTH-1:0] NULL_ELEV = {1'b1, {(ELEV_WIDTH-1){1'b0}}};

  // Request register
  logic                    req_vld_r;
  d8fd_in_t                req_r;

  // Elevations cut to the working width
  logic [ELEV_WIDTH-1:0]   center_e;
  logic [ELEV_WIDTH-1:0]   nbr_e [NBR_COUNT];
  logic signed [KEY_W-1:0] key_c [NBR_COUNT];
  logic [NBR_COUNT-1:0]    nbr_null_c;
  d8fd_ctrl_t              ctrl_c;

  // Slope key register
  logic                    key_vld_r;
  logic signed [KEY_W-1:0] key_r [NBR_COUNT];
  logic [NBR_COUNT-1:0]    kval_r;
  d8fd_ctrl_t              ctrl_r;

  // Tree output
  logic                    mx_vld;
  logic signed [KEY_W-1:0] mx_keys [NBR_COUNT];
  logic [NBR_COUNT-1:0]    mx_kval;
  d8fd_ctrl_t              mx_ctrl;
  logic signed [KEY_W-1:0] mx_max;
  logic                    mx_max_vld;

  d8fd_out_t               res_c;
  logic                    out_strobe_r;
  d8fd_out_t               out_result_r;

  // Never stall: every stage advances each cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= in_item;
  end

  // Take the low bits of each field, zero-extended where the width grows.
  assign center_e = ELEV_WIDTH'($unsigned(req_r.center_elev));
  assign nbr_e[0] = ELEV_WIDTH'($unsigned(req_r.nw_elev));
  assign nbr_e[1] = ELEV_WIDTH'($unsigned(req_r.north_elev));
  assign nbr_e[2] = ELEV_WIDTH'($unsigned(req_r.ne_elev));
  assign nbr_e[3] = ELEV_WIDTH'($unsigned(req_r.west_elev));
  assign nbr_e[4] = ELEV_WIDTH'($unsigned(req_r.east_elev));
  assign nbr_e[5] = ELEV_WIDTH'($unsigned(req_r.sw_elev));
  assign nbr_e[6] = ELEV_WIDTH'($unsigned(req_r.south_elev));
  assign nbr_e[7] = ELEV_WIDTH'($unsigned(req_r.se_elev));

  for (genvar g = 0; g < NBR_COUNT; g++) begin : g_slope
    d8fd_slope #(
      .ELEV_WIDTH (ELEV_WIDTH),
      .KEY_W      (KEY_W),
      .DIAG       (dir_diag(3'(g)))
    ) u_slope (
      .center_elev (center_e),
      .nbr_elev    (nbr_e[g]),
      .slope_key   (key_c[g]),
      .nbr_null    (nbr_null_c[g])
    );
  end

  // Border cells flow straight out; in the interior the last null
  // neighbour takes the discharge.
  always_comb begin
    ctrl_c.is_null    = (center_e == NULL_ELEV);
    ctrl_c.forced     = 1'b1;
    ctrl_c.forced_dir = '0;
    case (req_r.border_kind)
      BORDER_FIRST_ROW: ctrl_c.forced_dir = DIR_N;
      BORDER_LAST_ROW:  ctrl_c.forced_dir = DIR_S;
      BORDER_FIRST_COL: ctrl_c.forced_dir = DIR_W_;
      BORDER_LAST_COL:  ctrl_c.forced_dir = DIR_E;
      default: begin
        ctrl_c.forced = |nbr_null_c;
        for (int i = 0; i < NBR_COUNT; i++) begin
          if (nbr_null_c[i]) ctrl_c.forced_dir = dir_bit(3'(i));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= 1'b0;
    end else begin
      key_vld_r <= req_vld_r;
    end
  end

  // Null neighbours drop out of the maximum.
  always_ff @(posedge clk) begin
    key_r  <= key_c;
    kval_r <= ~nbr_null_c;
    ctrl_r <= ctrl_c;
  end

  d8fd_max #(
    .KEY_W (KEY_W)
  ) u_max (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (key_vld_r),
    .in_keys     (key_r),
    .in_kval     (kval_r),
    .in_ctrl     (ctrl_r),
    .out_vld     (mx_vld),
    .out_keys    (mx_keys),
    .out_kval    (mx_kval),
    .out_ctrl    (mx_ctrl),
    .out_max     (mx_max),
    .out_max_vld (mx_max_vld)
  );

  d8fd_resolve #(
    .KEY_W (KEY_W)
  ) u_resolve (
    .keys    (mx_keys),
    .kval    (mx_kval),
    .ctrl    (mx_ctrl),
    .max_key (mx_max),
    .max_vld (mx_max_vld),
    .result  (res_c)
  );

  // Result register: hold each result for exactly one strobe cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= mx_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= res_c;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  // Every result traces back to an accepted request.
  a_strobe_from_req : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 5))
    else $error("result strobe without a matching request");

  // A null centre always reports a zero direction.
  a_null_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.dir_is_null) |-> (out_result.flow_dir == '0))
    else $error("null centre with non-zero direction");

  // An unforced interior cell must have at least one usable neighbour.
  a_max_present : assert property (@(posedge clk) disable iff (!rst_n)
    (mx_vld && !mx_ctrl.forced && !mx_ctrl.is_null) |-> mx_max_vld)
    else $error("unforced request without a valid maximum");

endmodule

FILE: rtl/d8fd_slope.sv
// ============================================================================
// d8fd_slope : weighted drop toward one neighbour
// Drop from centre to neighbour scaled by the distance weight, so that
// cardinal and diagonal slopes compare as integers.
// ============================================================================
module d8fd_slope #(
  parameter int ELEV_WIDTH = 32,
  parameter int KEY_W      = 50,
  parameter bit DIAG       = 1'b0
) (
  input  logic [ELEV_WIDTH-1:0]   center_elev,
  input  logic [ELEV_WIDTH-1:0]   nbr_elev,
  output logic signed [KEY_W-1:0] slope_key,
  output logic                    nbr_null
);
  import d8fd_pkg::*;

  localparam logic [15:0]           WEIGHT    = DIAG ? Q15_ONE : Q15_SQRT2;
  localparam logic [ELEV_WIDTH-1:0] NULL_ELEV = {1'b1, {(ELEV_WIDTH-1){1'b0}}};

  logic signed [ELEV_WIDTH:0] drop;
  logic signed [KEY_W-1:0]    drop_x;
  logic signed [KEY_W-1:0]    weight_x;

  assign drop      = signed'({center_elev[ELEV_WIDTH-1], center_elev})
                   - signed'({nbr_elev[ELEV_WIDTH-1], nbr_elev});
  assign drop_x    = KEY_W'(drop);
  assign weight_x  = signed'(KEY_W'(WEIGHT));
  assign slope_key = drop_x * weight_x;
  assign nbr_null  = (nbr_elev == NULL_ELEV);

endmodule

FILE: rtl/d8fd_max.sv
// ============================================================================
// d8fd_max : registered maximum tree over the eight slope keys
// Two tree levels in the first stage, the final level in the second; the
// keys and control ride along so the resolve stage sees them aligned.
// ============================================================================
module d8fd_max #(
  parameter int KEY_W = 50
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [KEY_W-1:0]        in_keys [d8fd_pkg::NBR_COUNT],
  input  logic [d8fd_pkg::NBR_COUNT-1:0] in_kval,
  input  d8fd_pkg::d8fd_ctrl_t           in_ctrl,
  output logic                           out_vld,
  output logic signed [KEY_W-1:0]        out_keys [d8fd_pkg::NBR_COUNT],
  output logic [d8fd_pkg::NBR_COUNT-1:0] out_kval,
  output d8fd_pkg::d8fd_ctrl_t           out_ctrl,
  output logic signed [KEY_W-1:0]        out_max,
  output logic                           out_max_vld
);
  import d8fd_pkg::*;

  // Packed candidate: valid flag on top, key below.
  function automatic logic [KEY_W:0] pick_max(input logic [KEY_W:0] a,
                                              input logic [KEY_W:0] b);
    logic [KEY_W:0] r;
    if (!a[KEY_W])      r = b;
    else if (!b[KEY_W]) r = a;
    else if (signed'(a[KEY_W-1:0]) >= signed'(b[KEY_W-1:0])) r = a;
    else                r = b;
    return r;
  endfunction

  logic [KEY_W:0]          lvl1 [4];
  logic [KEY_W:0]          pair_nxt [2];

  logic                    a_vld_r;
  logic [KEY_W:0]          a_pair_r [2];
  logic signed [KEY_W-1:0] a_keys_r [NBR_COUNT];
  logic [NBR_COUNT-1:0]    a_kval_r;
  d8fd_ctrl_t              a_ctrl_r;

  logic                    b_vld_r;
  logic [KEY_W:0]          b_max_r;
  logic signed [KEY_W-1:0] b_keys_r [NBR_COUNT];
  logic [NBR_COUNT-1:0]    b_kval_r;
  d8fd_ctrl_t              b_ctrl_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = pick_max({in_kval[2*i], in_keys[2*i]}, {in_kval[2*i+1], in_keys[2*i+1]});
    end
    for (int j = 0; j < 2; j++) begin
      pair_nxt[j] = pick_max(lvl1[2*j], lvl1[2*j+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_pair_r <= pair_nxt;
    a_keys_r <= in_keys;
    a_kval_r <= in_kval;
    a_ctrl_r <= in_ctrl;
    b_max_r  <= pick_max(a_pair_r[0], a_pair_r[1]);
    b_keys_r <= a_keys_r;
    b_kval_r <= a_kval_r;
    b_ctrl_r <= a_ctrl_r;
  end

  assign out_vld     = b_vld_r;
  assign out_keys    = b_keys_r;
  assign out_kval    = b_kval_r;
  assign out_ctrl    = b_ctrl_r;
  assign out_max     = signed'(b_max_r[KEY_W-1:0]);
  assign out_max_vld = b_max_r[KEY_W];

endmodule

FILE: rtl/d8fd_resolve.sv
// ============================================================================
// d8fd_resolve : final direction code
// Sum the bits of every neighbour on the steepest drop, then apply the null,
// forced, flat and pit rules.
// ============================================================================
module d8fd_resolve #(
  parameter int KEY_W = 50
) (
  input  logic signed [KEY_W-1:0]        keys [d8fd_pkg::NBR_COUNT],
  input  logic [d8fd_pkg::NBR_COUNT-1:0] kval,
  input  d8fd_pkg::d8fd_ctrl_t           ctrl,
  input  logic signed [KEY_W-1:0]        max_key,
  input  logic                           max_vld,
  output d8fd_pkg::d8fd_out_t            result
);
  import d8fd_pkg::*;

  logic [DIR_W-1:0]         dir_sum;
  logic signed [FLOW_W-1:0] dir_pos;

  always_comb begin
    dir_sum = '0;
    for (int i = 0; i < NBR_COUNT; i++) begin
      if (kval[i] && (keys[i] == max_key)) dir_sum = dir_sum | dir_bit(3'(i));
    end
  end

  assign dir_pos = signed'({1'b0, dir_sum});

  always_comb begin
    result.dir_is_null = 1'b0;
    if (ctrl.is_null) begin
      result.flow_dir    = '0;
      result.dir_is_null = 1'b1;
    end else if (ctrl.forced) begin
      result.flow_dir = signed'({1'b0, ctrl.forced_dir});
    end else if (max_vld && (max_key == '0)) begin
      result.flow_dir = -dir_pos;
    end else if (max_vld && max_key[KEY_W-1]) begin
      result.flow_dir = FLOW_PIT;
    end else begin
      result.flow_dir = dir_pos;
    end
  end

endmodule
